// ===== rtl/core/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

	// Header layout: 16-bit little-endian total length, 16-bit type
	localparam int HEADER_BYTES = 4;
	localparam int HDR_CNT_W    = $clog2(HEADER_BYTES + 1);
	localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
	localparam int LEN_W        = 12;
	localparam int TYPE_W       = 16;

	// Queue between the front and the back; deep enough to hold a header
	// entry plus the payload bytes that arrive while it is expanded
	localparam int QUEUE_DEPTH  = 8;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(2048);

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_LOCAL_TYPE = 1'b0,
		REG_MAX_LEN    = 1'b1
	} cfg_reg_t;

	// Kind of work handed from the front to the back
	typedef enum logic [0:0] {
		KIND_BYTE   = 1'b0,	// one result: payload byte or length error
		KIND_HEADER = 1'b1	// HEADER_BYTES results from the gathered header
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       burst_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]        data_byte;
		logic              is_first;
		logic              is_last;
		logic [TYPE_W-1:0] packet_type;
		logic              to_local;
		logic              length_error;
	} out_item_t;

	typedef struct packed {
		logic [TYPE_W-1:0] local_type;
		logic [LEN_W-1:0]  max_packet_len;
	} cfg_t;

	typedef struct packed {
		kind_t                    kind;
		logic [HEADER_BYTES*8-1:0] data;	// header bytes, byte 0 lowest
		logic                     last;
		logic                     err;
		logic [TYPE_W-1:0]        ptype;
		logic                     to_local;
	} q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpd_front.sv =====
// ----------------------------------------------------------------------------
// lpd_front
// Byte intake: gathers the header, checks the length, counts the payload and
// posts work entries into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire logic             item_stall,
	input  wire lpd_pkg::in_item_t item,
	input  wire lpd_pkg::cfg_t    cfg,
	output      logic             push,
	output      lpd_pkg::q_entry_t push_entry
);

	logic [lpd_pkg::HDR_CNT_W-1:0] hdr_cnt_q;
	logic [7:0]                    hdr_q [lpd_pkg::HEADER_BYTES-1];
	logic [lpd_pkg::LEN_W-1:0]     rem_q;
	logic [lpd_pkg::TYPE_W-1:0]    type_q;

	logic                          accept;
	logic                          in_payload;
	logic                          hdr_done;
	logic [15:0]                   len;
	logic [lpd_pkg::TYPE_W-1:0]    new_type;
	logic                          bad_len;
	logic [lpd_pkg::LEN_W-1:0]     new_rem;

	// burst_end carries no framing meaning
	assign accept     = item_valid && !item_stall;
	assign in_payload = (hdr_cnt_q == lpd_pkg::HDR_CNT_W'(lpd_pkg::HEADER_BYTES));
	assign hdr_done   = (hdr_cnt_q == lpd_pkg::HDR_CNT_W'(lpd_pkg::HEADER_BYTES - 1));

	// Header decode with the incoming byte as the last header byte
	assign len      = {hdr_q[1], hdr_q[0]};
	assign new_type = {item.rx_byte, hdr_q[2]};
	assign bad_len  = (len < 16'(lpd_pkg::HEADER_BYTES)) ||
			(len > 16'(cfg.max_packet_len));
	assign new_rem  = lpd_pkg::LEN_W'(len - 16'(lpd_pkg::HEADER_BYTES));

	// Work entry for the back
	always_comb begin
		push                = 1'b0;
		push_entry.kind     = lpd_pkg::KIND_BYTE;
		push_entry.data     = {{(lpd_pkg::HEADER_BYTES-1)*8{1'b0}}, item.rx_byte};
		push_entry.last     = 1'b0;
		push_entry.err      = 1'b0;
		push_entry.ptype    = type_q;
		push_entry.to_local = (type_q == cfg.local_type);
		if (accept && in_payload) begin
			push            = 1'b1;
			push_entry.last = (rem_q <= lpd_pkg::LEN_W'(1));
		end else if (accept && hdr_done) begin
			push                = 1'b1;
			push_entry.ptype    = new_type;
			push_entry.to_local = (new_type == cfg.local_type);
			if (bad_len) begin
				push_entry.last = 1'b1;
				push_entry.err  = 1'b1;
			end else begin
				push_entry.kind = lpd_pkg::KIND_HEADER;
				push_entry.data = {item.rx_byte, hdr_q[2], hdr_q[1], hdr_q[0]};
				push_entry.last = (new_rem == '0);
			end
		end
	end

	// Header store: no reset, always written before it is read
	always_ff @(posedge clk) begin
		if (accept && !in_payload && !hdr_done) begin
			hdr_q[hdr_cnt_q[lpd_pkg::HDR_IDX_W-1:0]] <= item.rx_byte;
		end
	end

	// Framing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			rem_q     <= '0;
			type_q    <= '0;
		end else if (accept) begin
			if (in_payload) begin
				if (rem_q != '0) begin
					rem_q <= rem_q - lpd_pkg::LEN_W'(1);
				end
				if (rem_q <= lpd_pkg::LEN_W'(1)) begin
					hdr_cnt_q <= '0;
				end
			end else if (hdr_done) begin
				type_q <= new_type;
				if (bad_len) begin
					hdr_cnt_q <= '0;
					rem_q     <= '0;
				end else begin
					rem_q     <= new_rem;
					hdr_cnt_q <= (new_rem == '0) ? '0 :
						lpd_pkg::HDR_CNT_W'(lpd_pkg::HEADER_BYTES);
				end
			end else begin
				hdr_cnt_q <= hdr_cnt_q + lpd_pkg::HDR_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lpd_queue.sv =====
// ----------------------------------------------------------------------------
// lpd_queue
// Short FIFO of work entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lpd_pkg::q_entry_t push_entry,
	input  wire logic              pop,
	output      lpd_pkg::q_entry_t head,
	output      logic              empty,
	output      logic              full
);

	lpd_pkg::q_entry_t                entry_q [lpd_pkg::QUEUE_DEPTH];
	logic [lpd_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [lpd_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [lpd_pkg::QUEUE_CNT_W-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == lpd_pkg::QUEUE_CNT_W'(lpd_pkg::QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + lpd_pkg::QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lpd_pkg::QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + lpd_pkg::QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - lpd_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lpd_back.sv =====
// ----------------------------------------------------------------------------
// lpd_back
// Result sequencer: expands queue entries into result bytes, one a cycle while
// result_stall is low, through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lpd_pkg::q_entry_t  head,
	input  wire logic               empty,
	output      logic               pop,
	output      logic               result_valid,
	input  wire logic               result_stall,
	output      lpd_pkg::out_item_t result
);

	logic                          valid_q;
	lpd_pkg::out_item_t            result_q;
	logic [lpd_pkg::HDR_IDX_W-1:0] idx_q;

	logic                          load;
	logic                          take;
	logic                          idx_end;
	lpd_pkg::out_item_t            next_item;

	assign load    = !valid_q || !result_stall;
	assign take    = load && !empty;
	assign idx_end = (idx_q == lpd_pkg::HDR_IDX_W'(lpd_pkg::HEADER_BYTES - 1));
	assign pop     = take && ((head.kind == lpd_pkg::KIND_BYTE) || idx_end);

	// Result fields for the current entry and byte index
	always_comb begin
		next_item.packet_type  = head.ptype;
		next_item.to_local     = head.to_local;
		case (head.kind)
			lpd_pkg::KIND_HEADER: begin
				next_item.data_byte    = head.data[idx_q*8 +: 8];
				next_item.is_first     = (idx_q == '0);
				next_item.is_last      = idx_end && head.last;
				next_item.length_error = 1'b0;
			end
			default: begin
				next_item.data_byte    = head.data[7:0];
				next_item.is_first     = 1'b0;
				next_item.is_last      = head.last;
				next_item.length_error = head.err;
			end
		endcase
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= next_item;
		end
	end

	// Output valid and header byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= !empty;
			end
			if (pop) begin
				idx_q <= '0;
			end else if (take) begin
				idx_q <= idx_q + lpd_pkg::HDR_IDX_W'(1);
			end
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/length_prefixed_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Cuts a received byte stream into length-prefixed packets and tags bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : one stream byte per transfer (item_valid / item_stall).
//   result channel : one tagged packet byte per transfer (result_valid /
//                    result_stall). The four header bytes are held back until
//                    the header is complete, then released in order.
//   cfg channel    : register writes (cfg_valid / cfg_ready, always ready);
//                    write only while the block is idle.
// Path: a payload byte passes through the work queue and then the output register
//   before it is presented on the result port; the first header byte likewise
//   follows the fourth header byte through both.
// Throughput: one byte per cycle on both sides unless stalled, set by the
//   one-result-a-cycle output register; the eight-entry work queue absorbs header bursts.
// A bad length gives a single error result and the next byte starts a new
//   header.
// Reset: clears the framing counters, the queue pointers and the output valid;
//   local_type = 0, max_packet_len = 2048.
// Stall: a stalled result holds; the queue fills and item_stall rises once
//   it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_packet_deframer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output      logic               item_stall,
	input  wire lpd_pkg::in_item_t  item,
	output      logic               result_valid,
	input  wire logic               result_stall,
	output      lpd_pkg::out_item_t result,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	lpd_pkg::cfg_t     cfg_q;
	logic              push;
	lpd_pkg::q_entry_t push_entry;
	logic              pop;
	lpd_pkg::q_entry_t head;
	logic              empty;
	logic              full;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_type     <= '0;
			cfg_q.max_packet_len <= lpd_pkg::MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (lpd_pkg::cfg_reg_t'(cfg_index))
				lpd_pkg::REG_LOCAL_TYPE: cfg_q.local_type <= cfg_data;
				lpd_pkg::REG_MAX_LEN: begin
					cfg_q.max_packet_len <= cfg_data[lpd_pkg::LEN_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign item_stall = full;

	lpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg_q),
		.push       (push),
		.push_entry (push_entry)
	);

	lpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	lpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== rtl/core/lpd_checker.sv =====
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level checks of the deframer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire lpd_pkg::out_item_t result
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// An error result closes a run and never opens a packet
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.length_error |-> result.is_last && !result.is_first)
		else $error("length error result badly marked");

	// A packet start is never an error
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_first |-> !result.length_error)
		else $error("first byte flagged as length error");

	// The byte after a first byte that transfers follows without a gap and keeps the type
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.is_first |=>
		result_valid && !result.is_first &&
		result.packet_type == $past(result.packet_type))
		else $error("header bytes not contiguous");

endmodule

bind length_prefixed_packet_deframer lpd_checker u_lpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

// ===== bench/length_prefixed_packet_deframer_test.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_test
// Self-checking bench for the packet deframer. A short table of directed
// bytes covers the length extremes, header-only packets and bad lengths.
// Random packet streams follow under several register settings. Every result
// transfer is checked against its table entry or a software deframer that
// tracks the header, type and payload count. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_packet_deframer_test;

	localparam int IDLE_LIMIT = 2000;
	localparam int N_DIRECTED = 26;
	localparam lpd_pkg::out_item_t NONE = '0;

	// One directed byte; want is used only when typed is set
	typedef struct packed {
		logic [7:0]         rx_byte;
		logic               burst_end;
		logic               typed;
		lpd_pkg::out_item_t want;
	} stim_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	lpd_pkg::in_item_t  item = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	lpd_pkg::out_item_t result;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [0:0]         cfg_index = lpd_pkg::REG_LOCAL_TYPE;
	logic [15:0]        cfg_data = '0;

	// Deframer state as the bench sees it
	logic [lpd_pkg::TYPE_W-1:0]    cfg_local_type = '0;
	logic [lpd_pkg::LEN_W-1:0]     cfg_max_len = lpd_pkg::MAX_LEN_RESET;
	logic [7:0]                    hdr_bytes [lpd_pkg::HEADER_BYTES];
	logic [lpd_pkg::HDR_CNT_W-1:0] hdr_count = '0;
	logic [lpd_pkg::TYPE_W-1:0]    cur_type = '0;
	logic [lpd_pkg::LEN_W-1:0]     bytes_left = '0;

	lpd_pkg::out_item_t step_results[$];
	lpd_pkg::out_item_t expected_bytes[$];
	int                 mismatches = 0;
	int                 items_sent = 0;

	stim_row_t directed [N_DIRECTED] = '{
		// zero length straight after reset: error on the fourth byte
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b1, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1}},
		// header-only packet
		'{8'h04, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'h34, 1'b1, 1'b0, NONE},
		'{8'h12, 1'b0, 1'b0, NONE},
		// one over the default limit, all-ones type
		'{8'h01, 1'b0, 1'b0, NONE},
		'{8'h08, 1'b0, 1'b0, NONE},
		'{8'hFF, 1'b0, 1'b0, NONE},
		'{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b1}},
		// largest length field
		'{8'hFF, 1'b0, 1'b0, NONE},
		'{8'hFF, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b1, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1}},
		// one below the header size
		'{8'h03, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'hAA, 1'b0, 1'b0, NONE},
		'{8'h55, 1'b0, 1'b1, '{8'h55, 1'b0, 1'b1, 16'h55AA, 1'b0, 1'b1}},
		// two payload bytes, all-ones and top bit only
		'{8'h06, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'h00, 1'b0, 1'b0, NONE},
		'{8'hFF, 1'b1, 1'b0, NONE},
		'{8'h80, 1'b0, 1'b0, NONE}
	};

	length_prefixed_packet_deframer DUT (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Tag one emitted byte with the current type and route
	function automatic lpd_pkg::out_item_t tag_byte(logic [7:0] b, logic first,
			logic last, logic err);
		lpd_pkg::out_item_t r;
		r.data_byte    = b;
		r.is_first     = first;
		r.is_last      = last;
		r.packet_type  = cur_type;
		r.to_local     = (cur_type == cfg_local_type);
		r.length_error = err;
		return r;
	endfunction

	// Advance the framing by one stream byte, leaving its results in step_results
	task automatic deframe_byte(input logic [7:0] b);
		logic [15:0] len;
		step_results.delete();
		if (hdr_count >= lpd_pkg::HEADER_BYTES) begin
			step_results = {step_results, tag_byte(b, 1'b0, bytes_left <= 1, 1'b0)};
			if (bytes_left != 0)
				bytes_left--;
			if (bytes_left == 0)
				hdr_count = '0;
			return;
		end
		hdr_bytes[hdr_count[lpd_pkg::HDR_IDX_W-1:0]] = b;
		hdr_count++;
		if (hdr_count < lpd_pkg::HEADER_BYTES)
			return;
		len      = {hdr_bytes[1], hdr_bytes[0]};
		cur_type = {hdr_bytes[3], hdr_bytes[2]};
		if (len < lpd_pkg::HEADER_BYTES || len > cfg_max_len) begin
			step_results = {step_results, tag_byte(b, 1'b0, 1'b1, 1'b1)};
			hdr_count  = '0;
			bytes_left = '0;
			return;
		end
		bytes_left = lpd_pkg::LEN_W'(len - lpd_pkg::HEADER_BYTES);
		for (int i = 0; i < lpd_pkg::HEADER_BYTES; i++)
			step_results = {step_results, tag_byte(hdr_bytes[i], i == 0,
				i == lpd_pkg::HEADER_BYTES - 1 && bytes_left == 0, 1'b0)};
		if (bytes_left == 0)
			hdr_count = '0;
	endtask

	// One item transfer after a random gap; expectations queued at acceptance
	task automatic send_byte(input lpd_pkg::in_item_t it, input logic typed,
			input lpd_pkg::out_item_t want, input bit tight);
		int gap;
		gap = tight ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			@(negedge clk);
			item_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid = 1'b1;
		item = it;
		do @(posedge clk); while (item_stall);
		items_sent++;
		deframe_byte(it.rx_byte);
		if (typed)
			expected_bytes = {expected_bytes, want};
		else
			expected_bytes = {expected_bytes, step_results};
	endtask

	task automatic send_rand(input logic [7:0] b, input bit tight);
		send_byte('{rx_byte: b, burst_end: 1'($urandom_range(0, 1))}, 1'b0, NONE, tight);
	endtask

	task automatic write_reg(input lpd_pkg::cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == lpd_pkg::REG_LOCAL_TYPE)
			cfg_local_type = val;
		else
			cfg_max_len = val[lpd_pkg::LEN_W-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stop sending and wait for every outstanding result, plus pipeline slack
	task automatic settle;
		@(negedge clk);
		item_valid = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random stream: mostly good packets, some bad lengths, a little noise
	task automatic stream_packets(input int budget);
		int          start;
		int          kind;
		int          len;
		int          top;
		logic [15:0] ptype;
		bit          tight;
		start = items_sent;
		while (items_sent - start < budget) begin
			kind  = $urandom_range(0, 9);
			tight = ($urandom_range(0, 3) == 0);
			ptype = $urandom_range(0, 1) ? cfg_local_type : 16'($urandom);
			if (kind < 7 && cfg_max_len >= lpd_pkg::HEADER_BYTES) begin
				top = (cfg_max_len < 20) ? int'(cfg_max_len) : 20;
				if (cfg_max_len <= 64 && $urandom_range(0, 9) == 0)
					len = int'(cfg_max_len);
				else
					len = $urandom_range(lpd_pkg::HEADER_BYTES, top);
			end else if (kind < 9) begin
				if ($urandom_range(0, 1))
					len = $urandom_range(0, lpd_pkg::HEADER_BYTES - 1);
				else
					len = $urandom_range(int'(cfg_max_len) + 1, 65535);
			end else begin
				// stray bytes knock the framing out of step
				repeat ($urandom_range(1, 3)) send_rand(8'($urandom), tight);
				continue;
			end
			send_rand(len[7:0], tight);
			send_rand(len[15:8], tight);
			send_rand(ptype[7:0], tight);
			send_rand(ptype[15:8], tight);
			while (hdr_count >= lpd_pkg::HEADER_BYTES)
				send_rand(8'($urandom), tight);
		end
		// finish any header or payload left open
		while (hdr_count != 0)
			send_rand(8'($urandom), 1'b0);
	endtask

	task automatic run_setting(input logic [15:0] local_type, input logic [15:0] max_len,
			input int budget);
		write_reg(lpd_pkg::REG_LOCAL_TYPE, local_type);
		write_reg(lpd_pkg::REG_MAX_LEN, max_len);
		stream_packets(budget);
		settle();
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_result(input lpd_pkg::out_item_t got);
		lpd_pkg::out_item_t want;
		if (expected_bytes.size() == 0) begin
			$error("result with nothing expected: data_byte %0h", got.data_byte);
			mismatches++;
			return;
		end
		want = expected_bytes.pop_front();
		check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
		check_field("is_first", 16'(want.is_first), 16'(got.is_first));
		check_field("is_last", 16'(want.is_last), 16'(got.is_last));
		check_field("packet_type", want.packet_type, got.packet_type);
		check_field("to_local", 16'(want.to_local), 16'(got.to_local));
		check_field("length_error", 16'(want.length_error), 16'(got.length_error));
	endtask

	// Result side: random stall before each transfer, with stall-free stretches
	initial begin
		int gap;
		bit steady;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0)
				steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				@(negedge clk);
				result_stall = 1'b1;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			result_stall = 1'b0;
			do @(posedge clk); while (!result_valid);
			check_result(result);
		end
	end

	// Watchdog: too long without any transfer on any channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// Main sequence
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_byte('{rx_byte: directed[i].rx_byte, burst_end: directed[i].burst_end},
				directed[i].typed, directed[i].want, 1'b0);
		settle();

		run_setting(16'($urandom), 16'd2048, 90);
		run_setting(16'hFFFF, 16'd4, 50);
		// limit below the header size: every packet is a bad length
		run_setting(16'h0000, 16'd2, 30);
		run_setting(16'($urandom), 16'd40, 80);
		run_setting(16'($urandom), 16'($urandom_range(4, 300)), 90);

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== length_prefixed_packet_deframer.f =====
rtl/core/lpd_pkg.sv
rtl/core/lpd_front.sv
rtl/core/lpd_queue.sv
rtl/core/lpd_back.sv
rtl/core/length_prefixed_packet_deframer.sv
rtl/core/lpd_checker.sv
bench/length_prefixed_packet_deframer_test.sv
